[design/deq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared sizes, request and status codes, and transfer structs for the
// double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH  = 256;
  localparam int DATA_W = 32;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int REQ_W  = 3;
  localparam int STAT_W = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PEEK       = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic signed [DATA_W-1:0] value;
  } deq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic [CNT_W-1:0]         count;
    logic                     is_empty;
    logic [STAT_W-1:0]        status;
  } deq_out_t;

endpackage

[design/deq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/double_ended_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Ring-buffer deque of signed 32-bit values with push/pop at either end,
// clear and peek; every request reports both ends, count and status.
// ----------------------------------------------------------------------------
// channel   ports                  handshake
// request   start, busy, in_data   transfer when start && !busy
// result    out_valid, out_data    one-cycle strobe, no back-pressure
//
// accept in idle updates pointers and writes the entry ram; the resolve state
// then waits out the ram read latency for the new end element after a pop.
// the result strobes in the cycle after resolve, while the next request may
// already be accepted. reset clears state, head, count, read flags and strobe;
// ends, payload and entry ram are not swept. results cannot be stalled.
// ----------------------------------------------------------------------------
module double_ended_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  deq_pkg::deq_in_t  in_data,
  output logic              out_valid,
  output deq_pkg::deq_out_t out_data
);

  import deq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'b01,
    ST_RESOLVE = 2'b10
  } state_t;

  function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(DEPTH)) begin
      sum = sum - (CNT_W+1)'(DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  state_t                   state_r, state_nxt;
  logic [ADDR_W-1:0]        head_r, head_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic signed [DATA_W-1:0] front_r, front_nxt;
  logic signed [DATA_W-1:0] back_r, back_nxt;
  logic [STAT_W-1:0]        status_r, status_nxt;
  logic                     rd_front_r, rd_front_nxt;
  logic                     rd_back_r, rd_back_nxt;
  logic                     out_valid_r;
  deq_out_t                 out_data_r;

  logic                     accept;
  logic                     full;
  logic                     empty;
  logic                     wr_en;
  logic [ADDR_W-1:0]        wr_addr;
  logic                     rd_en;
  logic [ADDR_W-1:0]        rd_addr;
  logic [DATA_W-1:0]        rd_data;
  logic signed [DATA_W-1:0] front_res;
  logic signed [DATA_W-1:0] back_res;

  assign busy   = (state_r == ST_RESOLVE);
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);

  always_comb begin
    head_nxt     = head_r;
    count_nxt    = count_r;
    front_nxt    = front_r;
    back_nxt     = back_r;
    status_nxt   = STAT_OK;
    rd_front_nxt = 1'b0;
    rd_back_nxt  = 1'b0;
    wr_en        = 1'b0;
    wr_addr      = head_r;
    rd_en        = 1'b0;
    rd_addr      = head_r;
    unique case (in_data.req_type)
      REQ_PUSH_FRONT: begin
        if (full) begin
          status_nxt = STAT_OVERFLOW;
        end else begin
          head_nxt  = (head_r == '0) ? ADDR_W'(DEPTH - 1) : head_r - ADDR_W'(1);
          wr_en     = 1'b1;
          wr_addr   = head_nxt;
          count_nxt = count_r + CNT_W'(1);
          front_nxt = in_data.value;
          if (empty) begin
            back_nxt = in_data.value;
          end
        end
      end
      REQ_PUSH_BACK: begin
        if (full) begin
          status_nxt = STAT_OVERFLOW;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = ring_add(head_r, count_r);
          count_nxt = count_r + CNT_W'(1);
          back_nxt  = in_data.value;
          if (empty) begin
            front_nxt = in_data.value;
          end
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status_nxt = STAT_UNDERFLOW;
        end else begin
          head_nxt  = (head_r == ADDR_W'(DEPTH - 1)) ? '0 : head_r + ADDR_W'(1);
          count_nxt = count_r - CNT_W'(1);
          if (count_r != CNT_W'(1)) begin
            rd_en        = 1'b1;
            rd_addr      = head_nxt;
            rd_front_nxt = 1'b1;
          end
        end
      end
      REQ_POP_BACK: begin
        if (empty) begin
          status_nxt = STAT_UNDERFLOW;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          if (count_r != CNT_W'(1)) begin
            rd_en       = 1'b1;
            rd_addr     = ring_add(head_r, count_r - CNT_W'(2));
            rd_back_nxt = 1'b1;
          end
        end
      end
      REQ_CLEAR: begin
        head_nxt  = '0;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (accept) state_nxt = ST_RESOLVE;
      ST_RESOLVE: state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (accept && wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.value),
    .rd_en   (accept && rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign front_res = rd_front_r ? $signed(rd_data) : front_r;
  assign back_res  = rd_back_r  ? $signed(rd_data) : back_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      rd_front_r  <= 1'b0;
      rd_back_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= busy;
      if (accept) begin
        head_r     <= head_nxt;
        count_r    <= count_nxt;
        rd_front_r <= rd_front_nxt;
        rd_back_r  <= rd_back_nxt;
      end
    end
  end

  // cached ends and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      front_r  <= front_nxt;
      back_r   <= back_nxt;
      status_r <= status_nxt;
    end else if (busy) begin
      front_r                <= front_res;
      back_r                 <= back_res;
      out_data_r.front_value <= empty ? '0 : front_res;
      out_data_r.back_value  <= empty ? '0 : back_res;
      out_data_r.count       <= count_r;
      out_data_r.is_empty    <= empty;
      out_data_r.status      <= status_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe while a request is in flight");

  a_resolve_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid_r)
    else $error("request finished without a result transfer");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("stored count beyond depth");

  a_single_ram_read: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_front_r && rd_back_r))
    else $error("both ends flagged for ram refresh");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.is_empty == (out_data_r.count == '0)))
    else $error("empty flag disagrees with count");

endmodule
